/* hw/rtl/totp_pkg.sv */
package totp_pkg;

  // Datapath operation codes issued by the controller.
  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_CAPTURE    = 4'd1;
  localparam logic [3:0] OP_DIV_INIT   = 4'd2;
  localparam logic [3:0] OP_DIV_STEP   = 4'd3;
  localparam logic [3:0] OP_DIV_FIN    = 4'd4;
  localparam logic [3:0] OP_BLK_LOAD   = 4'd5;
  localparam logic [3:0] OP_ROUND      = 4'd6;
  localparam logic [3:0] OP_BLK_ADD    = 4'd7;
  localparam logic [3:0] OP_SAVE_INNER = 4'd8;
  localparam logic [3:0] OP_TRUNC      = 4'd9;
  localparam logic [3:0] OP_MOD_STEP   = 4'd10;
  localparam logic [3:0] OP_TOKEN_DONE = 4'd11;
  localparam logic [3:0] OP_PUBLISH    = 4'd12;

  // Time step slots.
  localparam logic [1:0] SLOT_NOW  = 2'd0;
  localparam logic [1:0] SLOT_PREV = 2'd1;
  localparam logic [1:0] SLOT_NEXT = 2'd2;

  // Hash blocks of one token.
  localparam logic [1:0] BLK_INNER_KEY = 2'd0;
  localparam logic [1:0] BLK_INNER_MSG = 2'd1;
  localparam logic [1:0] BLK_OUTER_KEY = 2'd2;
  localparam logic [1:0] BLK_OUTER_MSG = 2'd3;

  // Configuration register indexes.
  localparam logic [7:0] REG_KEY_A = 8'd0;
  localparam logic [7:0] REG_KEY_B = 8'd1;
  localparam logic [7:0] REG_KEY_C = 8'd2;
  localparam logic [7:0] REG_KEY_D = 8'd3;

  localparam logic [6:0] LAST_DIV_STEP = 7'd3;
  localparam logic [6:0] LAST_ROUND    = 7'd79;
  localparam logic [6:0] LAST_MOD_STEP = 7'd1;

  localparam logic [5:0]  STEP_SECONDS = 6'd30;
  localparam logic [31:0] TOKEN_MOD    = 32'd1000000;

  // Reciprocals for division by constants: for any 32-bit x, x / 30 equals
  // (x * RECIP_30) >> 36 and x / 1000000 equals (x * RECIP_MOD) >> 50.
  localparam logic [31:0] RECIP_30  = 32'h88888889;
  localparam logic [31:0] RECIP_MOD = 32'h431BDE83;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] blk;
    logic [6:0] cnt;
    logic [1:0] slot;
  } totp_cmd_t;

  typedef struct packed {
    logic is_validate;
  } totp_sts_t;

endpackage

/* hw/rtl/totp_ctrl.sv */
module totp_ctrl import totp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  totp_sts_t sts,
  output totp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV_INIT = 4'd1;
  localparam logic [3:0] S_DIV      = 4'd2;
  localparam logic [3:0] S_DIV_FIN  = 4'd3;
  localparam logic [3:0] S_LOAD     = 4'd4;
  localparam logic [3:0] S_ROUND    = 4'd5;
  localparam logic [3:0] S_ADD      = 4'd6;
  localparam logic [3:0] S_SAVE     = 4'd7;
  localparam logic [3:0] S_TRUNC    = 4'd8;
  localparam logic [3:0] S_MOD      = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;
  localparam logic [3:0] S_PUB      = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [1:0] blk_r, blk_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    blk_nxt       = blk_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.op        = OP_NONE;
    cmd.blk       = blk_r;
    cmd.cnt       = cnt_r;
    cmd.slot      = slot_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          slot_nxt  = SLOT_NOW;
          state_nxt = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == LAST_DIV_STEP) begin
          state_nxt = S_DIV_FIN;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_DIV_FIN: begin
        cmd.op    = OP_DIV_FIN;
        blk_nxt   = BLK_INNER_KEY;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.op    = OP_BLK_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.op = OP_ROUND;
        if (cnt_r == LAST_ROUND) begin
          state_nxt = S_ADD;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_ADD: begin
        cmd.op = OP_BLK_ADD;
        if (blk_r == BLK_INNER_MSG) begin
          state_nxt = S_SAVE;
        end else if (blk_r == BLK_OUTER_MSG) begin
          state_nxt = S_TRUNC;
        end else begin
          blk_nxt   = blk_r + 2'd1;
          state_nxt = S_LOAD;
        end
      end
      S_SAVE: begin
        cmd.op    = OP_SAVE_INNER;
        blk_nxt   = BLK_OUTER_KEY;
        state_nxt = S_LOAD;
      end
      S_TRUNC: begin
        cmd.op    = OP_TRUNC;
        cnt_nxt   = '0;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.op = OP_MOD_STEP;
        if (cnt_r == LAST_MOD_STEP) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_DONE: begin
        cmd.op = OP_TOKEN_DONE;
        if (sts.is_validate && (slot_r != SLOT_NEXT)) begin
          slot_nxt  = slot_r + 2'd1;
          state_nxt = S_DIV_INIT;
        end else begin
          state_nxt = S_PUB;
        end
      end
      S_PUB: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      blk_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      blk_r       <= blk_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/totp_dp.sv */
module totp_dp import totp_pkg::*; #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_opcode,
  input  logic [62:0] in_unix_time,
  input  logic [19:0] in_candidate_token,
  output logic [19:0] out_token_value,
  output logic        out_token_match,
  input  totp_cmd_t   cmd,
  output totp_sts_t   sts
);

  logic [63:0]  key_a_r, key_b_r, key_c_r, key_d_r;
  logic [255:0] key_mask;
  logic [255:0] key_vec;

  logic         op_r;
  logic [62:0]  time_r;
  logic [19:0]  cand_r;
  logic [63:0]  div_r;
  logic [4:0]   rem_r;
  logic         neg_r;
  logic [31:0]  h_r [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  w_r [16];
  logic [159:0] dig_r;
  logic [30:0]  modv_r;
  logic [11:0]  modq_r;
  logic [19:0]  tok_r;
  logic         match_r;
  logic [19:0]  out_token_r;
  logic         out_match_r;

  genvar gi;
  generate
    for (gi = 0; gi < 32; gi++) begin : g_mask
      assign key_mask[255-8*gi -: 8] = (gi < MAX_KEY_BYTES) ? 8'hFF : 8'h00;
    end
  endgenerate

  assign key_vec = {key_a_r, key_b_r, key_c_r, key_d_r} & key_mask;

  assign sts.is_validate = op_r;
  assign out_token_value = out_token_r;
  assign out_token_match = out_match_r;

  // Time variant for the current slot, as a 64-bit two's complement value.
  logic [63:0] t_sel;
  always_comb begin
    case (cmd.slot)
      SLOT_PREV: t_sel = {1'b0, time_r} - 64'(STEP_SECONDS);
      SLOT_NEXT: t_sel = {1'b0, time_r} + 64'(STEP_SECONDS);
      default:   t_sel = {1'b0, time_r};
    endcase
  end

  // Long division by 30 in 16-bit digits: the running remainder and the next
  // digit form a value below 30 * 2^16, divided by reciprocal multiplication.
  logic [20:0] div_part;
  logic [52:0] div_prod;
  logic [15:0] div_q;
  assign div_part = {rem_r, div_r[63:48]};
  assign div_prod = 53'(div_part) * 53'(RECIP_30);
  assign div_q    = div_prod[51:36];

  // Message words of the block being loaded.
  logic [31:0] blk_w [16];
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      blk_w[j] = 32'h0;
    end
    case (cmd.blk)
      BLK_INNER_KEY, BLK_OUTER_KEY: begin
        for (int j = 0; j < 16; j++) begin
          if (j < 8) begin
            blk_w[j] = key_vec[255-32*j -: 32];
          end
          blk_w[j] = blk_w[j] ^ ((cmd.blk == BLK_INNER_KEY) ? 32'h36363636 : 32'h5C5C5C5C);
        end
      end
      BLK_INNER_MSG: begin
        blk_w[0]  = div_r[63:32];
        blk_w[1]  = div_r[31:0];
        blk_w[2]  = 32'h80000000;
        blk_w[15] = 32'd576;
      end
      default: begin
        blk_w[0]  = dig_r[159:128];
        blk_w[1]  = dig_r[127:96];
        blk_w[2]  = dig_r[95:64];
        blk_w[3]  = dig_r[63:32];
        blk_w[4]  = dig_r[31:0];
        blk_w[5]  = 32'h80000000;
        blk_w[15] = 32'd672;
      end
    endcase
  end

  // One SHA-1 round.
  logic [31:0] f_v, k_v, tmp_v, w_new;
  always_comb begin
    if (cmd.cnt < 7'd20) begin
      f_v = (b_r & c_r) | (~b_r & d_r);
      k_v = 32'h5A827999;
    end else if (cmd.cnt < 7'd40) begin
      f_v = b_r ^ c_r ^ d_r;
      k_v = 32'h6ED9EBA1;
    end else if (cmd.cnt < 7'd60) begin
      f_v = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_v = 32'h8F1BBCDC;
    end else begin
      f_v = b_r ^ c_r ^ d_r;
      k_v = 32'hCA62C1D6;
    end
    tmp_v = {a_r[26:0], a_r[31:27]} + f_v + e_r + k_v + w_r[0];
    w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // Dynamic truncation of the final digest.
  logic [159:0] dig_now;
  logic [159:0] dig_shift;
  assign dig_now   = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
  assign dig_shift = dig_now << {h_r[4][3:0], 3'b000};

  // Quotient by 1000000 of the truncated value, by reciprocal multiplication.
  logic [62:0] mod_prod;
  assign mod_prod = 63'(modv_r) * 63'(RECIP_MOD);

  logic [19:0] tok_v;
  assign tok_v = modv_r[19:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0;
      key_b_r <= '0;
      key_c_r <= '0;
      key_d_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_A: key_a_r <= cfg_wdata;
        REG_KEY_B: key_b_r <= cfg_wdata;
        REG_KEY_C: key_c_r <= cfg_wdata;
        REG_KEY_D: key_d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= 1'b0;
    end else if (cmd.op == OP_CAPTURE) begin
      op_r <= in_opcode;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        time_r <= in_unix_time;
        cand_r <= in_candidate_token;
      end
      OP_DIV_INIT: begin
        neg_r  <= t_sel[63];
        div_r  <= t_sel[63] ? (~t_sel + 64'd1) : t_sel;
        rem_r  <= '0;
        h_r[0] <= IV0;
        h_r[1] <= IV1;
        h_r[2] <= IV2;
        h_r[3] <= IV3;
        h_r[4] <= IV4;
      end
      OP_DIV_STEP: begin
        div_r <= {div_r[47:0], div_q};
        rem_r <= 5'(div_part - 21'(div_q) * 21'(STEP_SECONDS));
      end
      OP_DIV_FIN: begin
        if (neg_r) begin
          div_r <= ~div_r + 64'd1;
        end
      end
      OP_BLK_LOAD: begin
        for (int j = 0; j < 16; j++) begin
          w_r[j] <= blk_w[j];
        end
        a_r <= h_r[0];
        b_r <= h_r[1];
        c_r <= h_r[2];
        d_r <= h_r[3];
        e_r <= h_r[4];
      end
      OP_ROUND: begin
        for (int j = 0; j < 15; j++) begin
          w_r[j] <= w_r[j+1];
        end
        w_r[15] <= w_new;
        a_r <= tmp_v;
        b_r <= a_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        d_r <= c_r;
        e_r <= d_r;
      end
      OP_BLK_ADD: begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end
      OP_SAVE_INNER: begin
        dig_r  <= dig_now;
        h_r[0] <= IV0;
        h_r[1] <= IV1;
        h_r[2] <= IV2;
        h_r[3] <= IV3;
        h_r[4] <= IV4;
      end
      OP_TRUNC: begin
        modv_r <= dig_shift[158:128];
      end
      OP_MOD_STEP: begin
        if (cmd.cnt == '0) begin
          modq_r <= mod_prod[61:50];
        end else begin
          modv_r <= modv_r - 31'(32'(modq_r) * TOKEN_MOD);
        end
      end
      OP_TOKEN_DONE: begin
        if (cmd.slot == SLOT_NOW) begin
          tok_r   <= tok_v;
          match_r <= (cand_r == tok_v);
        end else begin
          match_r <= match_r | (cand_r == tok_v);
        end
      end
      OP_PUBLISH: begin
        out_token_r <= tok_r;
        out_match_r <= match_r & op_r;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/totp_hmac_sha1_token_unit.sv */
// One transaction is handled at a time: a new input is taken only while the unit is idle.
// Each token costs a divide by 30 in 16-bit digits, four SHA-1 compressions on one
// shared round unit, and a modulo by reciprocal multiplication.
// Reset (rst_n, synchronous, active low) clears the controller, the output valid and
// the four key registers; there is no clearing pass.
module totp_hmac_sha1_token_unit import totp_pkg::*; #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [62:0] in_unix_time,
  input  logic [19:0] in_candidate_token,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_token_value,
  output logic        out_token_match
);

  // The controller sequences each token: time step division, the two HMAC
  // hashes of two blocks each, dynamic truncation and the decimal reduction.
  // A validate transaction runs that sequence for the current, previous and
  // next time steps. The result register lets a new input transaction be
  // taken while the last result is still waiting on the output side.
  totp_cmd_t cmd;
  totp_sts_t sts;

  totp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  totp_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_opcode          (in_opcode),
    .in_unix_time       (in_unix_time),
    .in_candidate_token (in_candidate_token),
    .out_token_value    (out_token_value),
    .out_token_match    (out_token_match),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule
